[src/lalp_pkg.sv]
// Shared types and constants for the LCG / additive lagged PRNG block.
package lalp_pkg;

   localparam int VALUE_W    = 16;
   localparam int HIST_DEPTH = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int DIVIDEND_W = 2 * VALUE_W + 1;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   localparam logic [VALUE_W-1:0] MODULUS_RST    = VALUE_W'(65535);
   localparam logic [VALUE_W-1:0] MULTIPLIER_RST = VALUE_W'(1);
   localparam logic [VALUE_W-1:0] INCREMENT_RST  = VALUE_W'(1);

   typedef enum logic {
      CMD_SEED = 1'b0,
      CMD_STEP = 1'b1
   } cmd_code_type;

   typedef enum logic [1:0] {
      MODE_LCG   = 2'd0,
      MODE_LAG25 = 2'd1,
      MODE_LAG37 = 2'd2,
      MODE_SPARE = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE       = 2'd0,
      CSR_MODULUS    = 2'd1,
      CSR_MULTIPLIER = 2'd2,
      CSR_INCREMENT  = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic push_seed;
      logic mul;
      logic div_step;
      logic finish;
   } dp_cmd_type;

endpackage

[src/lalp_ctrl.sv]
// Controller state machine: sequences multiply, serial modulo and result hand-off.
module lalp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_command,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lalp_pkg::dp_cmd_type dp_cmd
);
   import lalp_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;
   logic              accept;
   logic              last_step;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign last_step = (count_ff == CNT_W'(DIV_STEPS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_command == CMD_STEP)) state_in = ST_MUL;
         end
         ST_MUL:  state_in = ST_DIV;
         ST_DIV: begin
            if (last_step) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready       = 1'b0;
      dp_cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready        = 1'b1;
            dp_cmd.push_seed = req_valid && (req_command == CMD_SEED);
         end
         ST_MUL:  dp_cmd.mul      = 1'b1;
         ST_DIV:  dp_cmd.div_step = 1'b1;
         ST_DONE: dp_cmd.finish   = out_free;
         default: req_ready       = 1'b0;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (state_ff == ST_MUL) begin
         count_in = '0;
      end else if (state_ff == ST_DIV) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[src/lalp_dp.sv]
// Datapath: config registers, history line, multiply-add and bit-serial modulo.
module lalp_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [lalp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lalp_pkg::VALUE_W-1:0]         csr_wdata,
   input  logic [lalp_pkg::VALUE_W-1:0]         req_seed_value,
   input  lalp_pkg::dp_cmd_type                 dp_cmd,
   output logic [lalp_pkg::VALUE_W-1:0]         rsp_value
);
   import lalp_pkg::*;

   mode_type               mode_ff;
   logic [VALUE_W-1:0]     modulus_ff;
   logic [VALUE_W-1:0]     multiplier_ff;
   logic [VALUE_W-1:0]     increment_ff;

   logic [VALUE_W-1:0]     hist_ff [HIST_DEPTH];
   logic [VALUE_W-1:0]     push_value;
   logic                   push;

   logic [VALUE_W-1:0]     op_a, op_b, addend;
   logic [DIVIDEND_W-1:0]  sum_in;
   logic [DIVIDEND_W-1:0]  dividend_ff, dividend_in;
   logic [VALUE_W-1:0]     raw_low_ff;
   logic [VALUE_W-1:0]     rem_ff, rem_in;
   logic [VALUE_W:0]       trial;
   logic [VALUE_W-1:0]     result;
   logic [VALUE_W-1:0]     rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_LCG;
         modulus_ff    <= MODULUS_RST;
         multiplier_ff <= MULTIPLIER_RST;
         increment_ff  <= INCREMENT_RST;
      end else if (csr_write_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MODE:       mode_ff       <= mode_type'(csr_wdata[1:0]);
            CSR_MODULUS:    modulus_ff    <= csr_wdata;
            CSR_MULTIPLIER: multiplier_ff <= csr_wdata;
            CSR_INCREMENT:  increment_ff  <= csr_wdata;
            default:        mode_ff       <= mode_ff;
         endcase
      end
   end

   // operand select: hist_ff[k] holds x[-(k+1)]
   always_comb begin
      unique case (mode_ff)
         MODE_LAG25: begin
            op_a   = hist_ff[1];
            op_b   = VALUE_W'(1);
            addend = hist_ff[4];
         end
         MODE_LAG37: begin
            op_a   = hist_ff[2];
            op_b   = VALUE_W'(1);
            addend = hist_ff[6];
         end
         default: begin
            op_a   = multiplier_ff;
            op_b   = hist_ff[0];
            addend = increment_ff;
         end
      endcase
   end

   assign sum_in = DIVIDEND_W'(op_a * op_b) + DIVIDEND_W'(addend);

   // restoring modulo, one dividend bit per cycle, MSB first
   assign trial = {rem_ff, dividend_ff[DIVIDEND_W-1]};

   always_comb begin
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      if (dp_cmd.mul) begin
         dividend_in = sum_in;
         rem_in      = '0;
      end else if (dp_cmd.div_step) begin
         dividend_in = {dividend_ff[DIVIDEND_W-2:0], 1'b0};
         if (trial >= {1'b0, modulus_ff}) begin
            rem_in = VALUE_W'(trial - {1'b0, modulus_ff});
         end else begin
            rem_in = trial[VALUE_W-1:0];
         end
      end
   end

   // a zero modulus keeps the raw low bits
   assign result = (modulus_ff == '0) ? raw_low_ff : rem_ff;

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      if (dp_cmd.mul) begin
         raw_low_ff <= sum_in[VALUE_W-1:0];
      end
      if (dp_cmd.finish) begin
         rsp_value_ff <= result;
      end
   end

   assign push       = dp_cmd.push_seed || dp_cmd.finish;
   assign push_value = dp_cmd.finish ? result : req_seed_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (push) begin
         for (int i = HIST_DEPTH - 1; i > 0; i--) begin
            hist_ff[i] <= hist_ff[i-1];
         end
         hist_ff[0] <= push_value;
      end
   end

   assign rsp_value = rsp_value_ff;

endmodule

[src/lcg_and_additive_lagged_prng_top.sv]
// Top level of the three-mode PRNG: controller plus datapath.
//
//   channel | ports                                        | direction
//   req     | req_valid req_ready req_command req_seed_value| in
//   rsp     | rsp_valid rsp_ready rsp_value                | out
//   csr     | csr_write_en csr_index csr_wdata             | in
//
// A seed item is pushed into the history when accepted and the block stays ready.
// A step item passes through the accepting idle state, the multiply-add state,
// the one-bit-per-cycle modulo of the 33-bit sum and a hand-off state; the result
// is loaded into the output register at hand-off.
// The output register holds a finished item, so the next item is accepted
// while it waits; a stalled output only holds the following step at its end.
// Reset (synchronous) clears history to zero and loads the register defaults.
module lcg_and_additive_lagged_prng_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [lalp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lalp_pkg::VALUE_W-1:0]         csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_command,
   input  logic [lalp_pkg::VALUE_W-1:0]         req_seed_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [lalp_pkg::VALUE_W-1:0]         rsp_value
);
   import lalp_pkg::*;

   dp_cmd_type dp_cmd;

   lalp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .dp_cmd      (dp_cmd)
   );

   lalp_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_seed_value (req_seed_value),
      .dp_cmd         (dp_cmd),
      .rsp_value      (rsp_value)
   );

endmodule

[src/lalp_checker.sv]
// Port-level checker for the PRNG top level, with its bind statement.
module lalp_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [lalp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lalp_pkg::VALUE_W-1:0]         csr_wdata,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 req_command,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [lalp_pkg::VALUE_W-1:0]         rsp_value
);
   import lalp_pkg::*;

   logic [VALUE_W-1:0] modulus_ff;

   // shadow the modulus as written on the port
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RST;
      end else if (csr_write_en && (csr_idx_type'(csr_index) == CSR_MODULUS)) begin
         modulus_ff <= csr_wdata;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("result item dropped or changed while stalled");

   a_below_modulus: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (modulus_ff != '0) |-> rsp_value < modulus_ff)
      else $error("result not reduced below modulus");

   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == CMD_STEP) |=> !req_ready)
      else $error("step item did not occupy the block");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rise_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a step in progress");

endmodule

bind lcg_and_additive_lagged_prng_top lalp_checker u_lalp_checker (
   .clock        (clock),
   .reset        (reset),
   .csr_write_en (csr_write_en),
   .csr_index    (csr_index),
   .csr_wdata    (csr_wdata),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_command  (req_command),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_value    (rsp_value)
);
